// File: sv/fsr_pkg.sv
// Package for the per-sender sequence reorder unit.
// Holds sizing constants, the result status codes and the sequencer states.
// No dependencies; imported by fifo_sequence_reorder_unit.
package fsr_pkg;

    // Sizing of the sender table and the per-sender slot ring.
    localparam int SENDERS    = 8;
    localparam int WINDOW     = 16;
    localparam int SIDX_W     = $clog2(SENDERS);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int HELD_DEPTH = SENDERS * WINDOW;
    localparam int HELD_AW    = $clog2(HELD_DEPTH);
    localparam int NRES_W     = $clog2(WINDOW) + 1;

    // Fixed field widths of the streams.
    localparam int SENDER_W   = 3;
    localparam int SEQ_W      = 16;
    localparam int PAYLOAD_W  = 32;
    localparam int COUNT_W    = 4;
    localparam int TDATA_W    = 56;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    // Configuration register addresses.
    localparam logic [PADDR_W-1:0] ADDR_SENDER_COUNT = 2'd0;
    localparam logic [COUNT_W-1:0] SENDER_COUNT_RST  = 4'd8;

    // Largest sequence number; a count that reaches it stops advancing.
    localparam logic [SEQ_W-1:0] SEQ_MAX = 16'hFFFF;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_HELD      = 3'd1,
        ST_STALE     = 3'd2,
        ST_BEYOND    = 3'd3,
        ST_DUP       = 3'd4,
        ST_BAD       = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_DRAIN = 2'd2
    } state_t;

endpackage

// File: sv/fsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the held payload store.
module fsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/fifo_sequence_reorder_unit.sv
// Per-sender sequence reorder unit: top level. Depends on fsr_pkg and fsr_ram.
// The first result of an item comes from the result register once the item registers
// have captured it and S_EVAL has classified it. A new item is taken only in S_IDLE,
// after any drain of held entries that follows an in-order release; the drain is paced
// by the single result register and the held RAM's one read port, read once per entry.
// Reset (rst_n, asynchronous) clears delivered counts and slot valid bits and
// sets sender_count to 8; the payload RAM is not cleared and no sweep is run.
module fifo_sequence_reorder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream; s_tdata = {pad, payload[31:0], seq_number[15:0], sender[2:0]}
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fsr_pkg::TDATA_W-1:0]   s_tdata,
    // Result stream; m_tdata = {pad, out_payload[31:0], out_seq[15:0], out_sender[2:0]}
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fsr_pkg::TDATA_W-1:0]   m_tdata,
    // m_tuser = status[2:0]
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsr_pkg::PADDR_W-1:0]   paddr,
    input  logic [fsr_pkg::PDATA_W-1:0]   pwdata,
    output logic [fsr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import fsr_pkg::*;

    // Control and item registers.
    state_t                 state_reg, state_next;
    logic [SENDER_W-1:0]    snd_reg, snd_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic [PAYLOAD_W-1:0]   pay_reg, pay_next;
    logic [SEQ_W-1:0]       cnt_reg, cnt_next;
    logic [NRES_W-1:0]      nres_reg, nres_next;
    logic [COUNT_W-1:0]     sender_count_reg, sender_count_next;
    logic [SEQ_W-1:0]       delivered_reg [SENDERS];
    logic [SEQ_W-1:0]       delivered_next [SENDERS];
    logic [HELD_DEPTH-1:0]  valid_reg, valid_next;

    // Result register.
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SENDER_W-1:0]    out_sender_reg, out_sender_next;
    logic [SEQ_W-1:0]       out_seq_reg, out_seq_next;
    logic [PAYLOAD_W-1:0]   out_pay_reg, out_pay_next;
    status_t                out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    // RAM ports.
    logic                   ram_we;
    logic                   ram_re;
    logic [HELD_AW-1:0]     ram_waddr;
    logic [HELD_AW-1:0]     ram_raddr;
    logic [PAYLOAD_W-1:0]   ram_rdata;

    // Classification and drain look-ahead.
    logic [SIDX_W-1:0]      sidx;
    logic [SEQ_W-1:0]       cnt_cur;
    logic [SEQ_W-1:0]       diff;
    logic                   bad_sender;
    logic                   stale;
    logic                   in_order;
    logic                   beyond;
    logic                   dup;
    logic [HELD_AW-1:0]     item_addr;
    logic [SEQ_W-1:0]       chk_seq;
    logic [SEQ_W-1:0]       look_seq;
    logic [NRES_W-1:0]      nres_after;
    logic [HELD_AW-1:0]     look_addr;
    logic                   more;
    logic                   out_free;
    logic                   cfg_write;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sender screening and sequence classification of the captured item.
    assign sidx       = snd_reg[SIDX_W-1:0];
    assign bad_sender = ({1'b0, snd_reg} >= sender_count_reg) ||
                        (int'(snd_reg) >= SENDERS);
    assign cnt_cur    = delivered_reg[sidx];
    assign diff       = seq_reg - cnt_cur;
    assign stale      = (seq_reg <= cnt_cur);
    assign in_order   = (diff == 16'd1);
    assign beyond     = (diff > SEQ_W'(WINDOW - 1)) && !in_order;
    // WINDOW is a power of two, so the ring slot is the low bits of the number.
    assign item_addr  = {sidx, seq_reg[SLOT_W-1:0]};
    assign dup        = valid_reg[item_addr];

    // Shared look-ahead: is the number after the one being released held?
    assign chk_seq    = (state_reg == S_EVAL) ? seq_reg : (cnt_reg + 16'd1);
    assign nres_after = (state_reg == S_EVAL) ? NRES_W'(1) : (nres_reg + NRES_W'(1));
    assign look_seq   = chk_seq + 16'd1;
    assign look_addr  = {sidx, look_seq[SLOT_W-1:0]};
    assign more       = (chk_seq != SEQ_MAX) && (nres_after < NRES_W'(WINDOW)) &&
                        valid_reg[look_addr];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    if (!bad_sender && !stale && in_order && more)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free && !more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result generation for each state.
    always_comb
    begin
        snd_next        = snd_reg;
        seq_next        = seq_reg;
        pay_next        = pay_reg;
        cnt_next        = cnt_reg;
        nres_next       = nres_reg;
        delivered_next  = delivered_reg;
        valid_next      = valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_sender_next = out_sender_reg;
        out_seq_next    = out_seq_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = item_addr;
        ram_raddr       = look_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    snd_next = s_tdata[SENDER_W-1:0];
                    seq_next = s_tdata[SENDER_W +: SEQ_W];
                    pay_next = s_tdata[SENDER_W+SEQ_W +: PAYLOAD_W];
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    out_sender_next = snd_reg;
                    out_seq_next    = seq_reg;
                    out_pay_next    = '0;
                    out_last_next   = 1'b1;
                    if (bad_sender)
                    begin
                        out_status_next = ST_BAD;
                    end
                    else if (stale)
                    begin
                        out_status_next = ST_STALE;
                    end
                    else if (beyond)
                    begin
                        out_status_next = ST_BEYOND;
                    end
                    else if (!in_order)
                    begin
                        if (dup)
                        begin
                            out_status_next = ST_DUP;
                        end
                        else
                        begin
                            // Park the payload in the sender's ring.
                            out_status_next       = ST_HELD;
                            ram_we                = 1'b1;
                            valid_next[item_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        // In-order arrival: release it and start the drain.
                        out_status_next = ST_DELIVERED;
                        out_pay_next    = pay_reg;
                        out_last_next   = !more;
                        cnt_next        = seq_reg;
                        nres_next       = NRES_W'(1);
                        if (more)
                        begin
                            ram_re = 1'b1;
                        end
                        else
                        begin
                            delivered_next[sidx] = seq_reg;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    // Release the entry read at the previous release and look one further.
                    m_tvalid_next   = 1'b1;
                    out_sender_next = snd_reg;
                    out_seq_next    = chk_seq;
                    out_pay_next    = ram_rdata;
                    out_status_next = ST_DELIVERED;
                    out_last_next   = !more;
                    valid_next[{sidx, chk_seq[SLOT_W-1:0]}] = 1'b0;
                    cnt_next        = chk_seq;
                    nres_next       = nres_after;
                    if (more)
                    begin
                        ram_re = 1'b1;
                    end
                    else
                    begin
                        delivered_next[sidx] = chk_seq;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration port: always ready, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_SENDER_COUNT);
    assign prdata    = (paddr == ADDR_SENDER_COUNT) ?
                       {{(PDATA_W-COUNT_W){1'b0}}, sender_count_reg} : '0;

    always_comb
    begin
        sender_count_next = sender_count_reg;
        if (cfg_write)
        begin
            sender_count_next = pwdata[COUNT_W-1:0];
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            sender_count_reg <= SENDER_COUNT_RST;
            valid_reg        <= '0;
            for (int i = 0; i < SENDERS; i++)
            begin
                delivered_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            sender_count_reg <= sender_count_next;
            valid_reg        <= valid_next;
            delivered_reg    <= delivered_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        snd_reg        <= snd_next;
        seq_reg        <= seq_next;
        pay_reg        <= pay_next;
        cnt_reg        <= cnt_next;
        nres_reg       <= nres_next;
        out_sender_reg <= out_sender_next;
        out_seq_reg    <= out_seq_next;
        out_pay_reg    <= out_pay_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Held payload store.
    fsr_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (HELD_DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pay_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result stream outputs.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-SENDER_W-SEQ_W-PAYLOAD_W){1'b0}},
                       out_pay_reg, out_seq_reg, out_sender_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for fifo_sequence_reorder_unit.
// Streams sender messages in and checks each released or reported result against a
// cycle-free predictor of the per-sender reorder window. Depends on fsr_pkg.
`timescale 1ns / 1ps

module tb;
    import fsr_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_SENDER  = 6;

    // One message as it enters the block.
    typedef struct {
        logic [SENDER_W-1:0]  sender;
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] payload;
    } message_t;

    // One release or report as it leaves the block.
    typedef struct {
        logic [SENDER_W-1:0]  sender;
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] payload;
        status_t              status;
        logic                 last;
    } release_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Stimulus and expectation stores.
    message_t              messages_to_send [$];
    release_t              expected_releases [$];
    message_t              next_msg;
    int                    next_seq [SENDERS];
    bit                    gaps_on = 1'b0;
    int                    send_gap = 0;
    int                    sink_gap = 0;
    int                    quiet_cycles = 0;
    int                    mismatches = 0;

    // Predictor state: configuration, delivered counts and the parked slot rings.
    logic [COUNT_W-1:0]    sender_limit;
    logic [SEQ_W-1:0]      delivered_upto [SENDERS];
    logic [PAYLOAD_W-1:0]  parked_payload [HELD_DEPTH];
    bit                    parked_valid [HELD_DEPTH];

    fifo_sequence_reorder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the results one accepted message causes and queue them in order.
    function automatic void predict_reorder(input logic [SENDER_W-1:0] snd,
                                            input logic [SEQ_W-1:0] seq_in,
                                            input logic [PAYLOAD_W-1:0] pay);
        release_t r;
        int seq;
        int cnt;
        int base;
        int slot;
        int n;
        seq = int'(seq_in);
        cnt = int'(delivered_upto[snd]);
        base = int'(snd) * WINDOW;
        slot = base + seq % WINDOW;
        r.sender = snd;
        r.seq = seq_in;
        r.payload = '0;
        r.last = 1'b1;
        if (snd >= sender_limit || int'(snd) >= SENDERS)
            r.status = ST_BAD;
        else if (seq <= cnt)
            r.status = ST_STALE;
        else if (seq - cnt > WINDOW - 1 && seq != cnt + 1)
            r.status = ST_BEYOND;
        else if (seq != cnt + 1 && parked_valid[slot])
            r.status = ST_DUP;
        else if (seq != cnt + 1)
        begin
            parked_valid[slot] = 1'b1;
            parked_payload[slot] = pay;
            r.status = ST_HELD;
        end
        else
        begin
            // In-order arrival: release it, then drain the parked entries that follow.
            r.payload = pay;
            r.status = ST_DELIVERED;
            n = 1;
            cnt = seq;
            while (cnt < int'(SEQ_MAX) && n < WINDOW && parked_valid[base + (cnt + 1) % WINDOW])
            begin
                r.last = 1'b0;
                expected_releases.insert(expected_releases.size(), r);
                slot = base + (cnt + 1) % WINDOW;
                parked_valid[slot] = 1'b0;
                r.seq = SEQ_W'(cnt + 1);
                r.payload = parked_payload[slot];
                n++;
                cnt++;
            end
            delivered_upto[snd] = SEQ_W'(cnt);
            r.last = 1'b1;
        end
        expected_releases.insert(expected_releases.size(), r);
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    function automatic void add_msg(input int snd, input int seq, input logic [31:0] pay);
        message_t m;
        m.sender = SENDER_W'(snd);
        m.seq = SEQ_W'(seq);
        m.payload = pay;
        messages_to_send.insert(messages_to_send.size(), m);
    endfunction

    // A well-formed run: the next k numbers of one sender in shuffled order.
    function automatic int queue_run(input int snd);
        int order [$];
        int k;
        int i;
        int j;
        int t;
        k = $urandom_range(1, WINDOW - 1);
        for (i = 0; i < k; i++)
            order.insert(order.size(), next_seq[snd] + i);
        for (i = k - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < k; i++)
            add_msg(snd, order[i], $urandom());
        next_seq[snd] += k;
        return k;
    endfunction

    // Mostly well-formed runs over the active senders, with some noise mixed in.
    task automatic queue_random(input int count, input int active);
        int added;
        int pick;
        int snd;
        int s;
        added = 0;
        for (snd = 0; snd < SENDERS; snd++)
            next_seq[snd] = int'(delivered_upto[snd]) + 1;
        while (added < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                added += queue_run($urandom_range(0, active - 1));
            end
            else if (pick == 7)
            begin
                add_msg($urandom_range(0, 7), $urandom_range(0, 65535), $urandom());
                added++;
            end
            else if (pick == 8)
            begin
                // Stale number, then a parked number sent twice.
                snd = $urandom_range(0, active - 1);
                s = next_seq[snd] - $urandom_range(1, 3);
                add_msg(snd, (s < 0) ? 0 : s, $urandom());
                s = next_seq[snd] + $urandom_range(1, WINDOW - 2);
                add_msg(snd, s, $urandom());
                add_msg(snd, s, $urandom());
                added += 3;
            end
            else
            begin
                // Numbers around the far edge of the window, any sender.
                snd = $urandom_range(0, 7);
                add_msg(snd, next_seq[snd] + $urandom_range(WINDOW - 2, WINDOW + 4), $urandom());
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (messages_to_send.size() != 0 || s_tvalid || expected_releases.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access cycle; the register takes the value at the access edge.
    task automatic write_sender_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SENDER_COUNT;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sender_limit = value;
    endtask

    // Input driver: presents queued messages and predicts each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_reorder(s_tdata[2:0], s_tdata[18:3], s_tdata[50:19]);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (gaps_on && messages_to_send.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 12);
                    s_tvalid <= 1'b0;
                end
                else if (messages_to_send.size() != 0)
                begin
                    next_msg = messages_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {next_msg.payload, next_msg.seq, next_msg.sender};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_releases.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none, got tdata %0h tuser %0h tlast %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    compare_field("out_sender", 32'(expected_releases[0].sender),
                                  32'(m_tdata[2:0]));
                    compare_field("out_seq", 32'(expected_releases[0].seq),
                                  32'(m_tdata[18:3]));
                    compare_field("out_payload", expected_releases[0].payload,
                                  m_tdata[50:19]);
                    compare_field("status", 32'(expected_releases[0].status), 32'(m_tuser));
                    compare_field("last_of_run", 32'(expected_releases[0].last),
                                  32'(m_tlast));
                    void'(expected_releases.pop_front());
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer on any port.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        int i;
        int s;
        sender_limit = SENDER_COUNT_RST;
        for (i = 0; i < SENDERS; i++)
            delivered_upto[i] = '0;
        for (i = 0; i < HELD_DEPTH; i++)
            parked_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;

        // Directed: release, park, duplicate, drains, stale and window edges.
        add_msg(0, 1, 32'h0000_0000);
        add_msg(0, 3, 32'hFFFF_FFFF);
        add_msg(0, 3, 32'h1234_5678);
        add_msg(0, 5, 32'hA5A5_A5A5);
        add_msg(0, 2, 32'h5A5A_5A5A);
        add_msg(0, 4, 32'h0F0F_0F0F);
        add_msg(0, 1, 32'h1111_1111);
        add_msg(0, 0, 32'h2222_2222);
        add_msg(0, 5, 32'h3333_3333);
        add_msg(0, 21, 32'h4444_4444);
        add_msg(0, 20, 32'h5555_5555);
        add_msg(0, 65535, 32'hFFFF_FFFF);
        add_msg(7, 2, 32'h8000_0001);
        add_msg(7, 15, 32'h7FFF_FFFE);
        add_msg(7, 16, 32'h6666_6666);
        add_msg(7, 1, 32'hFFFF_FFFF);
        wait_idle();

        // Three senders in use: the upper ones are rejected.
        write_sender_count(4'd3);
        add_msg(3, 1, 32'h9999_9999);
        add_msg(7, 65535, 32'hFFFF_FFFF);
        add_msg(5, 0, 32'h0000_0000);
        queue_random(45, 3);
        wait_idle();

        // Single sender in use, with the sender held off once until everything has drained.
        write_sender_count(4'd1);
        queue_random(18, 1);
        wait_idle();
        queue_random(18, 1);
        wait_idle();

        // All senders in use; idling only in the first half.
        write_sender_count(4'd8);
        queue_random(26, 8);
        wait_idle();
        gaps_on = 1'b0;
        queue_random(26, 8);
        wait_idle();

        // Fill one sender's window, then release it with one number for the longest drain.
        s = int'(delivered_upto[DRAIN_SENDER]) + 1;
        for (i = s + WINDOW - 2; i > s; i--)
            add_msg(DRAIN_SENDER, i, $urandom());
        add_msg(DRAIN_SENDER, s, $urandom());
        add_msg(DRAIN_SENDER, s + 2, $urandom());
        add_msg(DRAIN_SENDER, 0, $urandom());
        wait_idle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
